FILE: src/urdf_pkg.sv
`timescale 1ns / 1ps

package urdf_pkg;

  localparam logic [7:0] SYNC_BYTE   = 8'h05;
  localparam logic [7:0] WRITE_FLAG  = 8'h80;
  localparam logic [7:0] MASTER_ADDR = 8'hFF;
  localparam logic [7:0] CRC_POLY    = 8'h07;

  // body bytes that follow the sync byte, before the CRC
  localparam logic [2:0] RD_BODY = 3'd2;
  localparam logic [2:0] WR_BODY = 3'd6;

  localparam logic [2:0] LAST_REPLY_POS = 3'd7;

  typedef enum logic [1:0] {
    ACT_READ  = 2'd0,
    ACT_WRITE = 2'd1,
    ACT_REPLY = 2'd2
  } action_t;

  typedef enum logic {
    KIND_TX   = 1'b0,
    KIND_READ = 1'b1
  } kind_t;

  typedef enum logic [2:0] {
    STAT_OK       = 3'd0,
    STAT_BAD_SYNC = 3'd1,
    STAT_BAD_ADDR = 3'd2,
    STAT_BAD_REG  = 3'd3,
    STAT_BAD_CRC  = 3'd4
  } status_t;

  typedef struct packed {
    logic        restart;
    logic        byte_en;
    logic [6:0]  reg_addr;
    logic [7:0]  reply_byte;
  } chk_req_t;

  typedef struct packed {
    logic        done;
    status_t     status;
    logic [31:0] value;
  } chk_res_t;

  typedef struct packed {
    logic        load;
    logic        step;
    logic        is_write;
    logic [7:0]  node;
    logic [6:0]  reg_addr;
    logic [31:0] write_value;
  } ser_req_t;

  typedef struct packed {
    logic        pending;
    logic [7:0]  tx_byte;
    logic        last;
  } ser_out_t;

  // CRC-8, poly 0x07, data taken LSB first
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      if (c[7] ^ data[i]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

FILE: src/urdf_in_if.sv
`timescale 1ns / 1ps

interface urdf_in_if;
  logic        valid;
  logic        ready;
  logic [1:0]  action;
  logic [6:0]  reg_addr;
  logic [31:0] write_value;
  logic [7:0]  reply_byte;

  modport source (output valid, output action, output reg_addr,
                  output write_value, output reply_byte, input ready);
  modport sink   (input valid, input action, input reg_addr,
                  input write_value, input reply_byte, output ready);
endinterface

FILE: src/urdf_out_if.sv
`timescale 1ns / 1ps

interface urdf_out_if;
  logic        valid;
  logic        ready;
  logic        kind;
  logic [7:0]  tx_byte;
  logic        last;
  logic [2:0]  read_status;
  logic [31:0] read_value;

  modport source (output valid, output kind, output tx_byte, output last,
                  output read_status, output read_value, input ready);
  modport sink   (input valid, input kind, input tx_byte, input last,
                  input read_status, input read_value, output ready);
endinterface

FILE: src/urdf_reply_checker.sv
`timescale 1ns / 1ps

module urdf_reply_checker
  import urdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  chk_req_t req,
  output chk_res_t res
);

  logic [2:0]  count_r, count_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [6:0]  exp_reg_r, exp_reg_nxt;
  status_t     err_r, err_nxt;
  logic [31:0] acc_r, acc_nxt;
  status_t     final_status;

  // result of the eighth byte, valid only when done is high
  always_comb begin
    if (err_r != STAT_OK) begin
      final_status = err_r;
    end else if (req.reply_byte != crc_r) begin
      final_status = STAT_BAD_CRC;
    end else begin
      final_status = STAT_OK;
    end
    res.done   = req.byte_en && (count_r == LAST_REPLY_POS);
    res.status = final_status;
    res.value  = (final_status == STAT_OK) ? acc_r : 32'd0;
  end

  always_comb begin
    count_nxt   = count_r;
    crc_nxt     = crc_r;
    exp_reg_nxt = exp_reg_r;
    err_nxt     = err_r;
    acc_nxt     = acc_r;
    if (req.restart) begin
      exp_reg_nxt = req.reg_addr;
      count_nxt   = 3'd0;
      crc_nxt     = 8'd0;
      err_nxt     = STAT_OK;
      acc_nxt     = 32'd0;
    end else if (req.byte_en) begin
      if (count_r == LAST_REPLY_POS) begin
        count_nxt = 3'd0;
        crc_nxt   = 8'd0;
        err_nxt   = STAT_OK;
        acc_nxt   = 32'd0;
      end else begin
        // only the first failing check is kept
        if (count_r == 3'd0) begin
          if (req.reply_byte != SYNC_BYTE && err_r == STAT_OK) begin
            err_nxt = STAT_BAD_SYNC;
          end
        end else if (count_r == 3'd1) begin
          if (req.reply_byte != MASTER_ADDR && err_r == STAT_OK) begin
            err_nxt = STAT_BAD_ADDR;
          end
        end else if (count_r == 3'd2) begin
          if (req.reply_byte != {1'b0, exp_reg_r} && err_r == STAT_OK) begin
            err_nxt = STAT_BAD_REG;
          end
        end else begin
          acc_nxt = {acc_r[23:0], req.reply_byte};
        end
        crc_nxt   = crc8_byte(crc_r, req.reply_byte);
        count_nxt = count_r + 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r   <= 3'd0;
      crc_r     <= 8'd0;
      exp_reg_r <= 7'd0;
      err_r     <= STAT_OK;
      acc_r     <= 32'd0;
    end else begin
      count_r   <= count_nxt;
      crc_r     <= crc_nxt;
      exp_reg_r <= exp_reg_nxt;
      err_r     <= err_nxt;
      acc_r     <= acc_nxt;
    end
  end

endmodule

FILE: src/urdf_tx_serialiser.sv
`timescale 1ns / 1ps

module urdf_tx_serialiser
  import urdf_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  ser_req_t req,
  output ser_out_t out
);

  logic        pending_r, pending_nxt;
  logic [2:0]  cnt_r, cnt_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [47:0] sh_r, sh_nxt;

  // body bytes leave from the top of the shift register, CRC comes last
  always_comb begin
    out.pending = pending_r;
    out.last    = (cnt_r == 3'd0);
    out.tx_byte = (cnt_r == 3'd0) ? crc_r : sh_r[47:40];
  end

  always_comb begin
    pending_nxt = pending_r;
    cnt_nxt     = cnt_r;
    crc_nxt     = crc_r;
    sh_nxt      = sh_r;
    if (req.load) begin
      // sync byte has already gone out with the load
      pending_nxt = 1'b1;
      crc_nxt     = crc8_byte(8'd0, SYNC_BYTE);
      if (req.is_write) begin
        cnt_nxt = WR_BODY;
        sh_nxt  = {req.node, WRITE_FLAG | {1'b0, req.reg_addr}, req.write_value};
      end else begin
        cnt_nxt = RD_BODY;
        sh_nxt  = {req.node, 1'b0, req.reg_addr, 32'd0};
      end
    end else if (req.step && pending_r) begin
      if (cnt_r == 3'd0) begin
        pending_nxt = 1'b0;
      end else begin
        crc_nxt = crc8_byte(crc_r, sh_r[47:40]);
        sh_nxt  = {sh_r[39:0], 8'd0};
        cnt_nxt = cnt_r - 3'd1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= 1'b0;
      cnt_r     <= 3'd0;
    end else begin
      pending_r <= pending_nxt;
      cnt_r     <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    crc_r <= crc_nxt;
    sh_r  <= sh_nxt;
  end

endmodule

FILE: src/uart_register_datagram_framer.sv
`timescale 1ns / 1ps
// UART register datagram framer and reply checker.
// in_ch: one beat is a read request, a write request or one received reply
//   byte (action field). out_ch: one beat is either a transmit byte (kind 0,
//   last high on the CRC byte) or a completed read reply (kind 1, status and
//   value). cfg_we/cfg_wdata write the node address placed in every datagram.
// A beat taken from in_ch sits in the input register; its first result is
//   presented on out_ch from the output register.
// A read request sends 4 datagram bytes, a write request 8 (one datagram
//   byte per cycle while out_ch.ready does not stall the output register, from
//   the transmit shift register, CRC built as the bytes go out). A reply byte
//   gives a result only on the eighth byte. While a datagram still has bytes
//   to send, a beat in the input register waits there and in_ch.ready is low.
// Reset clears the node address, the reply collection state and both valid
//   registers. When out_ch.ready is low the output register holds its beat
//   and the input register holds the next one; nothing is dropped.
module uart_register_datagram_framer
  import urdf_pkg::*;
(
  input  logic              clk,
  input  logic              rst_n,
  urdf_in_if.sink           in_ch,
  urdf_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [7:0]        cfg_wdata
);

  logic [7:0]  node_r;

  logic        s1_valid_r, s1_valid_nxt;
  logic [1:0]  s1_action_r;
  logic [6:0]  s1_reg_r;
  logic [31:0] s1_wval_r;
  logic [7:0]  s1_rb_r;

  logic        out_valid_r, out_valid_nxt;
  kind_t       out_kind_r, out_kind_nxt;
  logic [7:0]  out_tx_r, out_tx_nxt;
  logic        out_last_r, out_last_nxt;
  status_t     out_status_r, out_status_nxt;
  logic [31:0] out_value_r, out_value_nxt;

  logic        adv;
  logic        s1_take;
  logic        in_take;
  chk_req_t    chk_req;
  chk_res_t    chk_res;
  ser_req_t    ser_req;
  ser_out_t    ser_out;

  assign adv     = !out_valid_r || out_ch.ready;
  assign s1_take = s1_valid_r && adv && !ser_out.pending;
  assign in_take = in_ch.valid && in_ch.ready;

  assign in_ch.ready = !s1_valid_r || s1_take;

  always_comb begin
    chk_req.restart       = s1_take && (s1_action_r == ACT_READ);
    chk_req.byte_en       = s1_take && (s1_action_r == ACT_REPLY);
    chk_req.reg_addr      = s1_reg_r;
    chk_req.reply_byte    = s1_rb_r;

    ser_req.load          = s1_take && (s1_action_r == ACT_READ ||
                                        s1_action_r == ACT_WRITE);
    ser_req.step          = adv;
    ser_req.is_write      = (s1_action_r == ACT_WRITE);
    ser_req.node          = node_r;
    ser_req.reg_addr      = s1_reg_r;
    ser_req.write_value   = s1_wval_r;
  end

  urdf_reply_checker u_chk (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (chk_req),
    .res   (chk_res)
  );

  urdf_tx_serialiser u_ser (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (ser_req),
    .out   (ser_out)
  );

  always_comb begin
    s1_valid_nxt = s1_valid_r;
    if (in_take) begin
      s1_valid_nxt = 1'b1;
    end else if (s1_take) begin
      s1_valid_nxt = 1'b0;
    end
  end

  always_comb begin
    out_valid_nxt  = out_valid_r;
    out_kind_nxt   = out_kind_r;
    out_tx_nxt     = out_tx_r;
    out_last_nxt   = out_last_r;
    out_status_nxt = out_status_r;
    out_value_nxt  = out_value_r;
    if (adv) begin
      out_valid_nxt  = 1'b0;
      out_kind_nxt   = KIND_TX;
      out_tx_nxt     = 8'd0;
      out_last_nxt   = 1'b0;
      out_status_nxt = STAT_OK;
      out_value_nxt  = 32'd0;
      if (ser_out.pending) begin
        out_valid_nxt = 1'b1;
        out_tx_nxt    = ser_out.tx_byte;
        out_last_nxt  = ser_out.last;
      end else if (s1_valid_r) begin
        case (s1_action_r)
          ACT_READ, ACT_WRITE: begin
            out_valid_nxt = 1'b1;
            out_tx_nxt    = SYNC_BYTE;
          end
          ACT_REPLY: begin
            out_valid_nxt  = chk_res.done;
            out_kind_nxt   = KIND_READ;
            out_status_nxt = chk_res.status;
            out_value_nxt  = chk_res.value;
          end
          default: begin
            out_valid_nxt = 1'b0;
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      node_r      <= 8'd0;
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        node_r <= cfg_wdata;
      end
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_action_r <= in_ch.action;
      s1_reg_r    <= in_ch.reg_addr;
      s1_wval_r   <= in_ch.write_value;
      s1_rb_r     <= in_ch.reply_byte;
    end
    out_kind_r   <= out_kind_nxt;
    out_tx_r     <= out_tx_nxt;
    out_last_r   <= out_last_nxt;
    out_status_r <= out_status_nxt;
    out_value_r  <= out_value_nxt;
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.kind        = out_kind_r;
  assign out_ch.tx_byte     = out_tx_r;
  assign out_ch.last        = out_last_r;
  assign out_ch.read_status = out_status_r;
  assign out_ch.read_value  = out_value_r;

  // a waiting beat stays put while a datagram is still being sent
  a_no_take_while_sending: assert property (@(posedge clk) disable iff (!rst_n)
    (ser_out.pending && s1_valid_r) |-> !in_ch.ready)
    else $error("input taken while datagram bytes pending");

  // a request always opens its datagram with the sync byte
  a_sync_first: assert property (@(posedge clk) disable iff (!rst_n)
    ser_req.load |=> (out_valid_r && out_kind_r == KIND_TX && out_tx_r == SYNC_BYTE
                      && !out_last_r))
    else $error("datagram did not start with sync byte");

  // once the CRC beat is loaded the serialiser has nothing left
  a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_last_r) |-> !ser_out.pending)
    else $error("bytes left after last beat");

  // a failed reply never carries a value
  a_fail_no_value: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_kind_r == KIND_READ && out_status_r != STAT_OK)
      |-> (out_value_r == 32'd0))
    else $error("value reported with failed reply");

endmodule
